// ===== rtl/mrurp_pkg.sv =====
package mrurp_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int STAMP_BITS = 32;

    // field widths of the stream items
    localparam int OP_BITS   = 2;
    localparam int SET_BITS  = 6;
    localparam int WAY_BITS  = 3;
    localparam int WIU_BITS  = 4;
    localparam int WIU_RESET = 8;

    typedef logic [STAMP_BITS-1:0] stamp_t;

    typedef struct packed {
        stamp_t                clock;
        stamp_t [WAYS-1:0]     stamps;
    } row_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_TOUCH  = 2'd0,
        OP_VICTIM = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== rtl/mrurp_victim.sv =====
module mrurp_victim (
    input  mrurp_pkg::stamp_t [mrurp_pkg::WAYS-1:0] stamps,
    input  logic [mrurp_pkg::WIU_BITS-1:0]          limit,
    output logic [mrurp_pkg::WAY_BITS-1:0]          victim
);

    localparam int LVLS  = mrurp_pkg::WAY_BITS;
    localparam int NODES = 2 ** LVLS;

    mrurp_pkg::stamp_t             val [LVLS+1][NODES];
    logic [mrurp_pkg::WAY_BITS-1:0] idx [LVLS+1][NODES];

    // max tree; the right branch wins only when strictly greater, so ties
    // fall to the lower way and an all-zero set gives way 0
    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            for (int n = 0; n < NODES; n++) begin
                val[l][n] = '0;
                idx[l][n] = '0;
            end
        end
        for (int n = 0; n < NODES; n++) begin
            if (n < mrurp_pkg::WAYS && n < int'(limit)) begin
                val[0][n] = stamps[n];
            end
            idx[0][n] = mrurp_pkg::WAY_BITS'(n);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int n = 0; n < (NODES >> (l + 1)); n++) begin
                if (val[l][2*n+1] > val[l][2*n]) begin
                    val[l+1][n] = val[l][2*n+1];
                    idx[l+1][n] = idx[l][2*n+1];
                end else begin
                    val[l+1][n] = val[l][2*n];
                    idx[l+1][n] = idx[l][2*n];
                end
            end
        end
        victim = idx[LVLS][0];
    end

endmodule

// ===== rtl/mru_replacement_policy.sv =====
// MRU replacement policy for a set-associative cache.
// Input stream (s_): one operation per transaction, opcode in s_tuser
// (touch way, find victim, clear set), set and way in s_tdata.
// Result stream (m_): one transaction per victim query, victim way in m_tdata.
// Touch and clear produce no result.
// Configuration channel (cfg_): ways_in_use, always ready; write it only
// while the block is idle.
// Each set's clock and stamps live as one row of a synchronous RAM. In an
// operation the row is read on the accepting edge, then modified and
// written back (or compared for a victim) in the execute state.
// A victim result is then loaded into the registered output.
// A new operation is taken only once the current one leaves the execute
// state, as set by the single read-modify-write pass through the row RAM.
// Reset clears per-row valid bits, so every row reads as zero at once;
// ways_in_use returns to 8. No clearing pass is needed.
// If a result is waiting and m_tready is low, a following victim query
// holds in its execute cycle until the output register frees; touches and
// clears carry on regardless.
module mru_replacement_policy (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [5:0] set, [8:6] way, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0]  m_tdata,   // [2:0] victim_way, rest zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int SB = mrurp_pkg::SET_BITS;
    localparam int WB = mrurp_pkg::WAY_BITS;

    mrurp_pkg::state_t state_reg, state_next;

    mrurp_pkg::op_t                 op_reg;
    logic [SB-1:0]                  set_reg;
    logic [WB-1:0]                  way_reg;
    mrurp_pkg::row_t                rd_row_reg;
    logic                           rd_valid_reg;
    mrurp_pkg::row_t                row;
    mrurp_pkg::row_t                row_next;
    logic [mrurp_pkg::SETS-1:0]     valid_reg;
    logic [mrurp_pkg::WIU_BITS-1:0] wiu_reg;
    logic [mrurp_pkg::WIU_BITS-1:0] limit;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [WB-1:0]                  m_way_reg;
    logic [WB-1:0]                  victim;
    logic                           accept;
    logic                           exec_done;
    logic                           wr_en;
    logic                           out_load;
    logic                           set_ok;
    logic                           way_ok;
    mrurp_pkg::stamp_t              clock_inc;

    mrurp_pkg::row_t mem [mrurp_pkg::SETS];

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(8 - WB){1'b0}}, m_way_reg};

    // ---- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wiu_reg <= mrurp_pkg::WIU_BITS'(mrurp_pkg::WIU_RESET);
        end else if (cfg_valid && cfg_ready) begin
            wiu_reg <= cfg_data;
        end
    end

    assign limit = (int'(wiu_reg) > mrurp_pkg::WAYS) ?
                   mrurp_pkg::WIU_BITS'(mrurp_pkg::WAYS) : wiu_reg;

    // ---- operation capture and row read
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= mrurp_pkg::op_t'(s_tuser);
            set_reg      <= s_tdata[SB-1:0];
            way_reg      <= s_tdata[SB +: WB];
            rd_row_reg   <= mem[s_tdata[SB-1:0]];
            rd_valid_reg <= valid_reg[s_tdata[SB-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[set_reg] <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[set_reg] <= 1'b1;
        end
    end

    // a row never written reads as all zero
    assign row       = rd_valid_reg ? rd_row_reg : '0;
    assign set_ok    = int'(set_reg) < mrurp_pkg::SETS;
    assign way_ok    = int'(way_reg) < mrurp_pkg::WAYS;
    assign clock_inc = row.clock + 1'b1;

    always_comb begin
        row_next = row;
        case (op_reg)
            mrurp_pkg::OP_TOUCH: begin
                row_next.clock           = clock_inc;
                row_next.stamps[way_reg] = clock_inc;
            end
            mrurp_pkg::OP_CLEAR: begin
                row_next = '0;
            end
            default: begin
                row_next = row;
            end
        endcase
    end

    mrurp_victim u_victim (
        .stamps (row.stamps),
        .limit  (limit),
        .victim (victim)
    );

    // ---- sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mrurp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = mrurp_pkg::ST_EXEC;
                end
            end
            mrurp_pkg::ST_EXEC: begin
                if (exec_done) begin
                    state_next = mrurp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrurp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        exec_done = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            mrurp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            mrurp_pkg::ST_EXEC: begin
                exec_done = !(op_reg == mrurp_pkg::OP_VICTIM && m_tvalid_reg && !m_tready);
                out_load  = exec_done && op_reg == mrurp_pkg::OP_VICTIM;
                wr_en     = set_ok && ((op_reg == mrurp_pkg::OP_TOUCH && way_ok) ||
                                       op_reg == mrurp_pkg::OP_CLEAR);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrurp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---- result register
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_way_reg <= set_ok ? victim : '0;
        end
    end

endmodule

// ===== tb/mru_stamp_checker.sv =====
`timescale 1ns / 100ps

module mru_stamp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] set, [8:6] way, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [2:0] victim_way, rest zero
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          victims_due
);

    localparam int SB = mrurp_pkg::SET_BITS;
    localparam int WB = mrurp_pkg::WAY_BITS;
    localparam int NB = mrurp_pkg::WIU_BITS;

    mrurp_pkg::stamp_t set_clock [mrurp_pkg::SETS];
    mrurp_pkg::stamp_t way_stamp [mrurp_pkg::SETS][mrurp_pkg::WAYS];
    logic [NB-1:0]     scan_ways;
    logic [WB-1:0]     victim_q [$];

    function automatic logic [WB-1:0] newest_way(input int set);
        int                limit;
        mrurp_pkg::stamp_t best;
        logic [WB-1:0]     winner;
        limit  = (int'(scan_ways) > mrurp_pkg::WAYS) ? mrurp_pkg::WAYS : int'(scan_ways);
        best   = '0;
        winner = '0;
        // strict compare: ties keep the lower way, all-zero keeps way 0
        for (int w = 0; w < limit; w++) begin
            if (way_stamp[set][w] > best) begin
                best   = way_stamp[set][w];
                winner = w[WB-1:0];
            end
        end
        return winner;
    endfunction

    always @(posedge aclk) begin : watch
        logic [WB-1:0] want;
        logic [SB-1:0] set;
        logic [WB-1:0] way;
        if (!aresetn) begin
            for (int s = 0; s < mrurp_pkg::SETS; s++) begin
                set_clock[s] = '0;
                for (int w = 0; w < mrurp_pkg::WAYS; w++) way_stamp[s][w] = '0;
            end
            scan_ways  = NB'(mrurp_pkg::WIU_RESET);
            fail_count = 0;
            victim_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (victim_q.size() == 0) begin
                    $error("victim_way: no result expected, got %0d",
                           m_tdata[WB-1:0]);
                    fail_count++;
                end else begin
                    want = victim_q.pop_front();
                    if (m_tdata[WB-1:0] !== want) begin
                        $error("victim_way: expected %0d, got %0d",
                               want, m_tdata[WB-1:0]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                scan_ways = cfg_data;
            if (s_tvalid && s_tready) begin
                set = s_tdata[SB-1:0];
                way = s_tdata[SB +: WB];
                case (s_tuser)
                    mrurp_pkg::OP_TOUCH: begin
                        set_clock[set]      = set_clock[set] + 1'b1;
                        way_stamp[set][way] = set_clock[set];
                    end
                    mrurp_pkg::OP_VICTIM: begin
                        victim_q.push_back(newest_way(int'(set)));
                    end
                    mrurp_pkg::OP_CLEAR: begin
                        set_clock[set] = '0;
                        for (int w = 0; w < mrurp_pkg::WAYS; w++) way_stamp[set][w] = '0;
                    end
                    default: ;  // unused opcode: no effect, no result
                endcase
            end
        end
        victims_due = victim_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam logic [mrurp_pkg::OP_BITS-1:0] OP_UNUSED   = 2'd3;
    localparam int                            CYCLE_LIMIT = 1_000_000;
    localparam int                            HOLD_CYCLES = 400;
    localparam int                            SB          = mrurp_pkg::SET_BITS;
    localparam int                            WB          = mrurp_pkg::WAY_BITS;
    localparam int                            NB          = mrurp_pkg::WIU_BITS;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [5:0] set, [8:6] way, rest zero
    logic [1:0]  s_tuser;    // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [2:0] victim_way, rest zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    int fail_count;
    int victims_due;
    int cycles;
    bit no_gap;
    bit hold_req;

    mru_replacement_policy DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mru_stamp_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .victims_due (victims_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("mru_replacement_policy test failed");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random ready pattern, plus a long hold-off on request
    initial begin : result_sink
        int r;
        int len;
        m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 8);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    len = pick_gap() + 1;
                end else begin
                    m_tready <= 1'b1;
                    len = $urandom_range(100, 200);
                end
                repeat (len) @(posedge aclk);
            end
        end
    end

    // s_tvalid is only lowered when a gap follows, so back-to-back
    // transactions never see a low and a high in the same step
    task automatic issue_op(input logic [mrurp_pkg::OP_BITS-1:0] op, input int set,
                            input int way);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, way[WB-1:0], set[SB-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every victim result is in and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (victims_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_scan_ways(input logic [NB-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit press);
        int                            done;
        int                            r;
        int                            hot_base;
        int                            set;
        logic [mrurp_pkg::OP_BITS-1:0] op;
        done     = 0;
        hot_base = $urandom_range(0, mrurp_pkg::SETS - 4);
        if (press) begin
            // receiver stops for a long stretch while queries keep coming
            hold_req = 1'b1;
            no_gap   = 1'b1;
            repeat (30) begin
                issue_op(mrurp_pkg::OP_VICTIM, hot_base + $urandom_range(0, 3),
                         $urandom_range(0, mrurp_pkg::WAYS - 1));
                done++;
            end
            no_gap = 1'b0;
        end
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 58)      op = mrurp_pkg::OP_TOUCH;
            else if (r < 88) op = mrurp_pkg::OP_VICTIM;
            else if (r < 93) op = mrurp_pkg::OP_CLEAR;
            else             op = OP_UNUSED;
            // most traffic on a few sets so stamps build up
            if ($urandom_range(0, 99) < 80) set = hot_base + $urandom_range(0, 3);
            else                            set = $urandom_range(0, mrurp_pkg::SETS - 1);
            issue_op(op, set, $urandom_range(0, mrurp_pkg::WAYS - 1));
            done++;
        end
    endtask

    initial begin : stimulus
        logic [NB-1:0] plan [7];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        no_gap    = 1'b0;
        hold_req  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty set, recency order, both end sets, unused opcode,
        // clear, then narrow, zero and oversized scan widths
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);
        issue_op(mrurp_pkg::OP_TOUCH, 0, 7);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);
        issue_op(mrurp_pkg::OP_TOUCH, 0, 3);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 7);
        issue_op(mrurp_pkg::OP_TOUCH, 63, 0);
        issue_op(mrurp_pkg::OP_TOUCH, 63, 1);
        issue_op(mrurp_pkg::OP_TOUCH, 63, 2);
        issue_op(mrurp_pkg::OP_VICTIM, 63, 0);
        issue_op(mrurp_pkg::OP_TOUCH, 63, 0);
        issue_op(mrurp_pkg::OP_VICTIM, 63, 0);
        issue_op(OP_UNUSED, 63, 5);
        issue_op(mrurp_pkg::OP_VICTIM, 63, 0);
        issue_op(mrurp_pkg::OP_CLEAR, 63, 0);
        issue_op(mrurp_pkg::OP_VICTIM, 63, 0);
        issue_op(mrurp_pkg::OP_TOUCH, 63, 5);
        issue_op(mrurp_pkg::OP_VICTIM, 63, 0);
        write_scan_ways(4'd4);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);
        write_scan_ways(4'd0);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);
        write_scan_ways(4'd15);
        issue_op(mrurp_pkg::OP_TOUCH, 42, 6);
        issue_op(mrurp_pkg::OP_VICTIM, 42, 0);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);
        write_scan_ways(4'd1);
        issue_op(mrurp_pkg::OP_TOUCH, 0, 0);
        issue_op(mrurp_pkg::OP_VICTIM, 0, 0);

        plan = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd4,
                 4'($urandom_range(0, 15)), 4'($urandom_range(1, 8))};
        for (int p = 0; p < 7; p++) begin
            write_scan_ways(plan[p]);
            no_gap = (p == 3);
            run_random(200, (p == 1) || (p == 5));
            no_gap = 1'b0;
        end

        settle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && victims_due == 0) begin
            $display("mru_replacement_policy test passed");
        end else begin
            $display("mru_replacement_policy test failed");
        end
        $finish;
    end

endmodule
